[rtl/core/dphy_tc_pkg.sv]
// Types, constants and helper functions for the D-PHY timing calculator.
package dphy_tc_pkg;

  localparam int RATE_W   = 32;
  localparam int RECIP_W  = 29;
  localparam int RECIP_SH = 38;
  localparam int KW       = 23;
  localparam int UI_W     = 30;
  localparam int DIV_W    = UI_W + 3;
  localparam int NUM_W    = 34;
  localparam int QW       = 9;
  localparam int SHW      = DIV_W + QW;
  localparam int NLANE    = 13;
  localparam int CW       = 12;
  localparam int NPOST    = 4;

  localparam logic [RECIP_W-1:0] RECIP_1000 = 29'd274877907;
  localparam logic [RATE_W-1:0]  LOW_RATE   = 32'd1000;
  localparam logic [UI_W-1:0]    UI_NUM     = 30'd1000000000;

  localparam int LN_CPREP_MIN  = 0;
  localparam int LN_CPREP_MAX  = 1;
  localparam int LN_CZERO      = 2;
  localparam int LN_CTRAIL_MIN = 3;
  localparam int LN_CTRAIL_MAX = 4;
  localparam int LN_HPREP_MIN  = 5;
  localparam int LN_HPREP_MAX  = 6;
  localparam int LN_HZERO      = 7;
  localparam int LN_HTRAIL_MIN = 8;
  localparam int LN_HTRAIL_MAX = 9;
  localparam int LN_RQST       = 10;
  localparam int LN_HEXIT      = 11;
  localparam int LN_CPOST      = 12;

  localparam logic [6:0] PCT_CPREP  = 7'd50;
  localparam logic [6:0] PCT_CZERO  = 7'd2;
  localparam logic [6:0] PCT_CTRAIL = 7'd30;
  localparam logic [6:0] PCT_HPREP  = 7'd50;
  localparam logic [6:0] PCT_HZERO  = 7'd10;
  localparam logic [6:0] PCT_HTRAIL = 7'd30;
  localparam logic [6:0] PCT_HEXIT  = 7'd10;
  localparam logic [6:0] PCT_CPOST  = 7'd10;
  localparam logic [6:0] PCT_CPRE   = 7'd10;

  typedef logic signed [CW-1:0] cnt_t;

  localparam cnt_t CNT_ONE  = cnt_t'(1);
  localparam cnt_t CNT_PRE  = cnt_t'(6);
  localparam cnt_t CNT_63   = cnt_t'(63);
  localparam cnt_t CNT_126  = cnt_t'(126);
  localparam cnt_t CNT_127  = cnt_t'(127);
  localparam cnt_t CNT_255  = cnt_t'(255);
  localparam cnt_t CNT_511  = cnt_t'(511);
  localparam cnt_t CNT_NEG  = cnt_t'(-255);

  typedef struct packed {
    cnt_t cprep;
    cnt_t czero;
    cnt_t ctrail;
    cnt_t hprep;
    cnt_t hzero;
    cnt_t htrail;
    cnt_t rqst;
    cnt_t hexit;
    cnt_t cpost;
    cnt_t c2;
    cnt_t f2;
    cnt_t c7;
    cnt_t f7;
    cnt_t czmin;
    cnt_t hzmin;
    cnt_t cpmin;
    logic low;
  } post_t;

  // numerator of each lane, divided by 8*ui downstream
  function automatic logic [NUM_W-1:0] lane_num(input int lane, input logic [UI_W-1:0] ui);
    logic [NUM_W-1:0] u;
    u = NUM_W'(ui);
    case (lane)
      LN_CPREP_MIN:  return NUM_W'(38000);
      LN_CPREP_MAX:  return NUM_W'(95000);
      LN_CZERO:      return NUM_W'(300000);
      LN_CTRAIL_MIN: return NUM_W'(60000) + NUM_W'(3) * u;
      LN_CTRAIL_MAX: return NUM_W'(85000) + NUM_W'(15) * u;
      LN_HPREP_MIN:  return NUM_W'(40000) + NUM_W'(4) * u;
      LN_HPREP_MAX:  return NUM_W'(85000) + NUM_W'(6) * u;
      LN_HZERO:      return NUM_W'(145000) + NUM_W'(10) * u;
      LN_HTRAIL_MIN: return NUM_W'(60000) + NUM_W'(4) * u;
      LN_HTRAIL_MAX: return NUM_W'(85000) + NUM_W'(12) * u;
      LN_RQST:       return NUM_W'(50000);
      LN_HEXIT:      return NUM_W'(100000);
      LN_CPOST:      return NUM_W'(60000) + NUM_W'(9) * u;
      default:       return '0;
    endcase
  endfunction

  // tmin + round-away((tmax - tmin) * pct / 100), floored at zero
  function automatic cnt_t interp(input cnt_t tmax, input cnt_t tmin, input logic [6:0] pct);
    logic signed [CW:0]   diff;
    logic signed [CW+8:0] prod;
    logic [CW+8:0]        mag;
    logic [CW+22:0]       scl;
    logic [CW-1:0]        c;
    logic signed [CW+1:0] v;
    diff = {tmax[CW-1], tmax} - {tmin[CW-1], tmin};
    prod = $signed({{8{diff[CW]}}, diff}) * $signed({{(CW+2){1'b0}}, pct});
    mag  = prod[CW+8] ? $unsigned(-prod) : $unsigned(prod);
    // ceil(mag / 100) by reciprocal
    scl  = ({14'd0, mag} + (CW+23)'(99)) * (CW+23)'(5243);
    c    = scl[CW+18:19];
    if (prod[CW+8]) begin
      v = {tmin[CW-1], tmin[CW-1], tmin} - {2'b00, c};
    end else begin
      v = {tmin[CW-1], tmin[CW-1], tmin} + {2'b00, c};
    end
    return v[CW+1] ? '0 : v[CW-1:0];
  endfunction

  function automatic logic [8:0] clamp_u(input cnt_t v, input cnt_t hi);
    if (v[CW-1]) begin
      return '0;
    end else if (v > hi) begin
      return hi[8:0];
    end
    return v[8:0];
  endfunction

endpackage

[rtl/core/dphy_timing_calculator.sv]
// D-PHY timing calculator: bit rate in, timing counts out, fully pipelined.
//
// channel | signals                         | dir | beat
// in      | in_valid_i / in_ready_o         | in  | bit_rate_hz_i
// out     | out_valid_o / out_ready_i       | out | valid_res_o .. clk_pre_doubled_o
//
// One beat per cycle sustained while the output is not stalled.
// The path runs through the 30-stage restoring divider for ui (one bit per stage)
// and the 9-stage divider array by 8*ui (13 lanes, one bit per stage).
// rst_ni clears only the valid bits; the data path needs no reset.
// A stall on the output freezes every stage together, so nothing is lost.
module dphy_timing_calculator (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [dphy_tc_pkg::RATE_W-1:0] bit_rate_hz_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       valid_res_o,
  output logic [7:0] clk_prep_o,
  output logic [8:0] clk_zr_o,
  output logic [7:0] clk_trl_o,
  output logic [7:0] hs_prep_o,
  output logic [7:0] hs_zero_o,
  output logic [7:0] hs_trl_o,
  output logic signed [8:0] hs_rqst_o,
  output logic [7:0] hs_exit_o,
  output logic [5:0] clk_pst_o,
  output logic [6:0] clk_pre_o,
  output logic       clk_pre_doubled_o
);
  import dphy_tc_pkg::*;

  logic en;
  logic out_valid_q;

  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = out_valid_q;

  // input register
  logic              s0_v_q;
  logic [RATE_W-1:0] s0_rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (en) begin
      s0_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_rate_q <= bit_rate_hz_i;
    end
  end

  // rate / 1000 by reciprocal
  logic [RATE_W+RECIP_W-1:0] kprod;
  logic [KW-1:0]             k_d;

  assign kprod = {{RECIP_W{1'b0}}, s0_rate_q} * {{RATE_W{1'b0}}, RECIP_1000};
  assign k_d   = kprod[RECIP_SH+KW-1:RECIP_SH];

  // ui = 1e9 / k, one quotient bit per stage
  logic [UI_W:0]   ua_v_q;
  logic            ua_low_q [UI_W+1];
  logic [KW-1:0]   ua_k_q   [UI_W+1];
  logic [KW-1:0]   ua_r_q   [UI_W+1];
  logic [UI_W-1:0] ua_q_q   [UI_W+1];
  logic [KW:0]     ua_rs    [UI_W];
  logic            ua_ge    [UI_W];
  logic [KW:0]     ua_sub   [UI_W];
  logic [KW-1:0]   ua_rn    [UI_W];
  logic [UI_W-1:0] ua_qn    [UI_W];

  always_comb begin
    for (int j = 0; j < UI_W; j++) begin
      ua_rs[j]  = {ua_r_q[j], UI_NUM[UI_W-1-j]};
      ua_ge[j]  = ua_rs[j] >= {1'b0, ua_k_q[j]};
      ua_sub[j] = ua_rs[j] - {1'b0, ua_k_q[j]};
      ua_rn[j]  = ua_ge[j] ? ua_sub[j][KW-1:0] : ua_rs[j][KW-1:0];
      ua_qn[j]  = ua_q_q[j];
      ua_qn[j][UI_W-1-j] = ua_ge[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ua_v_q <= '0;
    end else if (en) begin
      ua_v_q <= {ua_v_q[UI_W-1:0], s0_v_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ua_low_q[0] <= s0_rate_q < LOW_RATE;
      ua_k_q[0]   <= k_d;
      ua_r_q[0]   <= '0;
      ua_q_q[0]   <= '0;
      for (int j = 0; j < UI_W; j++) begin
        ua_low_q[j+1] <= ua_low_q[j];
        ua_k_q[j+1]   <= ua_k_q[j];
        ua_r_q[j+1]   <= ua_rn[j];
        ua_q_q[j+1]   <= ua_qn[j];
      end
    end
  end

  // numerators divided by 8*ui, 13 lanes, one quotient bit per stage
  logic [QW:0]        db_v_q;
  logic               db_low_q [QW+1];
  logic [DIV_W-1:0]   db_d_q   [QW+1];
  logic [NUM_W-1:0]   db_r_q   [QW+1][NLANE];
  logic [QW-1:0]      db_q_q   [QW+1][NLANE];
  logic [SHW-1:0]     db_sh    [QW];
  logic               db_ge    [QW][NLANE];
  logic [NUM_W-1:0]   db_rn    [QW][NLANE];
  logic [QW-1:0]      db_qn    [QW][NLANE];
  logic [NUM_W-1:0]   num_d    [NLANE];

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      num_d[l] = lane_num(l, ua_q_q[UI_W]);
    end
    for (int j = 0; j < QW; j++) begin
      db_sh[j] = SHW'(db_d_q[j]) << (QW - 1 - j);
      for (int l = 0; l < NLANE; l++) begin
        db_ge[j][l] = SHW'(db_r_q[j][l]) >= db_sh[j];
        db_rn[j][l] = db_ge[j][l] ? db_r_q[j][l] - db_sh[j][NUM_W-1:0] : db_r_q[j][l];
        db_qn[j][l] = db_q_q[j][l];
        db_qn[j][l][QW-1-j] = db_ge[j][l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      db_v_q <= '0;
    end else if (en) begin
      db_v_q <= {db_v_q[QW-1:0], ua_v_q[UI_W]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      db_low_q[0] <= ua_low_q[UI_W];
      db_d_q[0]   <= {ua_q_q[UI_W], 3'b000};
      for (int l = 0; l < NLANE; l++) begin
        db_r_q[0][l] <= num_d[l];
        db_q_q[0][l] <= '0;
      end
      for (int j = 0; j < QW; j++) begin
        db_low_q[j+1] <= db_low_q[j];
        db_d_q[j+1]   <= db_d_q[j];
        for (int l = 0; l < NLANE; l++) begin
          db_r_q[j+1][l] <= db_rn[j][l];
          db_q_q[j+1][l] <= db_qn[j][l];
        end
      end
    end
  end

  // count post-processing
  cnt_t  fq [NLANE];
  cnt_t  cq [NLANE];
  logic [NPOST-1:0] pe_v_q;
  post_t pe_q [NPOST];
  post_t pe_d [NPOST];

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      fq[l] = $signed({{(CW-QW){1'b0}}, db_q_q[QW][l]});
      cq[l] = $signed({{(CW-QW){1'b0}}, db_q_q[QW][l]} +
                      {{(CW-1){1'b0}}, |db_r_q[QW][l]});
    end

    pe_d[0]        = '0;
    pe_d[0].low    = db_low_q[QW];
    pe_d[0].cprep  = interp(fq[LN_CPREP_MAX], cq[LN_CPREP_MIN], PCT_CPREP);
    pe_d[0].ctrail = interp(fq[LN_CTRAIL_MAX], cq[LN_CTRAIL_MIN], PCT_CTRAIL);
    pe_d[0].hprep  = interp(fq[LN_HPREP_MAX], cq[LN_HPREP_MIN], PCT_HPREP);
    pe_d[0].htrail = interp(fq[LN_HTRAIL_MAX] - CNT_ONE, cq[LN_HTRAIL_MIN] - CNT_ONE,
                            PCT_HTRAIL);
    pe_d[0].rqst   = (fq[LN_RQST] != '0) ? cq[LN_RQST] - CNT_ONE : -CNT_ONE;
    pe_d[0].hexit  = interp(CNT_255, cq[LN_HEXIT] - CNT_ONE, PCT_HEXIT);
    pe_d[0].cpost  = interp(CNT_63, cq[LN_CPOST] - CNT_ONE, PCT_CPOST);
    pe_d[0].c2     = cq[LN_CZERO];
    pe_d[0].f2     = fq[LN_CZERO];
    pe_d[0].c7     = cq[LN_HZERO];
    pe_d[0].f7     = fq[LN_HZERO];

    // sign of (C - m*8ui) picks ceil or floor
    pe_d[1]       = pe_q[0];
    pe_d[1].czmin = ((pe_q[0].cprep <= pe_q[0].f2) ? pe_q[0].c2 - pe_q[0].cprep
                                                   : pe_q[0].f2 - pe_q[0].cprep) - CNT_ONE;
    pe_d[1].hzmin = ((pe_q[0].hprep <= pe_q[0].f7) ? pe_q[0].c7 - pe_q[0].hprep
                                                   : pe_q[0].f7 - pe_q[0].hprep) - CNT_ONE;

    pe_d[2]       = pe_q[1];
    pe_d[2].czero = interp((pe_q[1].czmin > CNT_255) ? CNT_511 : CNT_255, pe_q[1].czmin,
                           PCT_CZERO);
    pe_d[2].hzero = interp(CNT_255, pe_q[1].hzmin, PCT_HZERO);

    pe_d[3]       = pe_q[2];
    pe_d[3].cpmin = pe_q[2].cprep + pe_q[2].czero + pe_q[2].rqst + CNT_PRE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pe_v_q <= '0;
    end else if (en) begin
      pe_v_q <= {pe_v_q[NPOST-2:0], db_v_q[QW]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int s = 0; s < NPOST; s++) begin
        pe_q[s] <= pe_d[s];
      end
    end
  end

  // output stage
  cnt_t       cpre_v;
  logic       dbl_v;
  cnt_t       rq_v;
  logic [8:0] c_prep, c_zero, c_trail, h_prep, h_zero, h_trail, h_exit, c_post, c_pre;

  always_comb begin
    if (pe_q[NPOST-1].cpmin > CNT_63) begin
      cpre_v = interp(CNT_126, pe_q[NPOST-1].cpmin, PCT_CPRE) >>> 1;
      dbl_v  = 1'b1;
    end else begin
      cpre_v = interp(CNT_63, pe_q[NPOST-1].cpmin, PCT_CPRE);
      dbl_v  = 1'b0;
    end
    if (pe_q[NPOST-1].rqst > CNT_255) begin
      rq_v = CNT_255;
    end else if (pe_q[NPOST-1].rqst < CNT_NEG) begin
      rq_v = CNT_NEG;
    end else begin
      rq_v = pe_q[NPOST-1].rqst;
    end
    c_prep  = clamp_u(pe_q[NPOST-1].cprep, CNT_255);
    c_zero  = clamp_u(pe_q[NPOST-1].czero, CNT_511);
    c_trail = clamp_u(pe_q[NPOST-1].ctrail, CNT_255);
    h_prep  = clamp_u(pe_q[NPOST-1].hprep, CNT_255);
    h_zero  = clamp_u(pe_q[NPOST-1].hzero, CNT_255);
    h_trail = clamp_u(pe_q[NPOST-1].htrail, CNT_255);
    h_exit  = clamp_u(pe_q[NPOST-1].hexit, CNT_255);
    c_post  = clamp_u(pe_q[NPOST-1].cpost, CNT_63);
    c_pre   = clamp_u(cpre_v, CNT_127);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= pe_v_q[NPOST-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (pe_q[NPOST-1].low) begin
        valid_res_o       <= 1'b0;
        clk_prep_o        <= '0;
        clk_zr_o          <= '0;
        clk_trl_o         <= '0;
        hs_prep_o         <= '0;
        hs_zero_o         <= '0;
        hs_trl_o          <= '0;
        hs_rqst_o         <= '0;
        hs_exit_o         <= '0;
        clk_pst_o         <= '0;
        clk_pre_o         <= '0;
        clk_pre_doubled_o <= 1'b0;
      end else begin
        valid_res_o       <= 1'b1;
        clk_prep_o        <= c_prep[7:0];
        clk_zr_o          <= c_zero;
        clk_trl_o         <= c_trail[7:0];
        hs_prep_o         <= h_prep[7:0];
        hs_zero_o         <= h_zero[7:0];
        hs_trl_o          <= h_trail[7:0];
        hs_rqst_o         <= rq_v[8:0];
        hs_exit_o         <= h_exit[7:0];
        clk_pst_o         <= c_post[5:0];
        clk_pre_o         <= c_pre[6:0];
        clk_pre_doubled_o <= dbl_v;
      end
    end
  end

  a_low_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !valid_res_o |-> clk_prep_o == '0 && clk_zr_o == '0 &&
      clk_trl_o == '0 && hs_prep_o == '0 && hs_zero_o == '0 && hs_trl_o == '0 &&
      hs_rqst_o == '0 && hs_exit_o == '0 && clk_pst_o == '0 && clk_pre_o == '0 &&
      !clk_pre_doubled_o)
    else $error("low-rate beat carries nonzero timings");

  a_dbl_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clk_pre_doubled_o |-> valid_res_o && clk_pre_o >= 7'd32)
    else $error("doubled clk_pre out of range");

  a_rqst_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> hs_rqst_o != 9'h100)
    else $error("hs_rqst not saturated");

endmodule
